// ===== design/lepg_pkg.sv =====
// Package for the LED effect pixel generator.
// Holds the colour type, effect and register codes, timing and hash constants,
// and the small arithmetic helpers that the top level and its stages use.
`timescale 1ns / 1ps
`default_nettype none

package lepg_pkg;

  // One colour, eight bits a channel.
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Sixteen-bit sums for the three channels ahead of a divide by 255.
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } sum3_t;

  // Effect codes.
  localparam logic [3:0] EffAmbient = 4'd0;
  localparam logic [3:0] EffSolid   = 4'd1;
  localparam logic [3:0] EffRainbow = 4'd2;
  localparam logic [3:0] EffBreath  = 4'd3;
  localparam logic [3:0] EffWarm    = 4'd4;
  localparam logic [3:0] EffBias    = 4'd5;
  localparam logic [3:0] EffSunset  = 4'd6;
  localparam logic [3:0] EffCandle  = 4'd7;
  localparam logic [3:0] EffAurora  = 4'd8;
  localparam logic [3:0] EffTwinkle = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] RegEffectMode = 3'd0;
  localparam logic [2:0] RegSpeed      = 3'd1;
  localparam logic [2:0] RegIntensity  = 3'd2;
  localparam logic [2:0] RegColorRed   = 3'd3;
  localparam logic [2:0] RegColorGreen = 3'd4;
  localparam logic [2:0] RegColorBlue  = 3'd5;
  localparam logic [2:0] RegLedCount   = 3'd6;

  // Longest strip that is rendered.
  localparam logic [10:0] MaxLeds = 11'd1024;

  // Slow and fast periods or steps in microseconds for each animated effect.
  localparam logic [24:0] RainbowSlow = 25'd12000000;
  localparam logic [24:0] RainbowFast = 25'd1200000;
  localparam logic [24:0] BreathSlow  = 25'd8000000;
  localparam logic [24:0] BreathFast  = 25'd1400000;
  localparam logic [24:0] CandleSlow  = 25'd220000;
  localparam logic [24:0] CandleFast  = 25'd60000;
  localparam logic [24:0] AuroraSlow  = 25'd18000000;
  localparam logic [24:0] AuroraFast  = 25'd2200000;
  localparam logic [24:0] TwinkleSlow = 25'd480000;
  localparam logic [24:0] TwinkleFast = 25'd90000;

  // Reciprocal of 255 for 32-bit dividends: q = (x * Recip255) >> 39.
  localparam logic [31:0] Recip255 = 32'h80808081;

  // Hash and seed multipliers.
  localparam logic [31:0] HashMulA    = 32'h7feb352d;
  localparam logic [31:0] HashMulB    = 32'h846ca68b;
  localparam logic [31:0] SeedCandle  = 32'h9e3779b9;
  localparam logic [31:0] SeedTwinkle = 32'h85ebca6b;

  // Fixed colours.
  localparam rgb_t WarmRgb    = '{8'd255, 8'd172, 8'd92};
  localparam rgb_t BiasRgb    = '{8'd255, 8'd249, 8'd253};
  localparam rgb_t CandleRgb  = '{8'd255, 8'd116, 8'd22};
  localparam rgb_t SunsetA    = '{8'd255, 8'd78, 8'd18};
  localparam rgb_t SunsetB    = '{8'd225, 8'd22, 8'd96};
  localparam rgb_t SunsetC    = '{8'd92, 8'd18, 8'd130};
  localparam rgb_t AuroraBlue = '{8'd16, 8'd70, 8'd255};
  localparam rgb_t AuroraCyan = '{8'd0, 8'd220, 8'd200};
  localparam rgb_t AuroraGrn  = '{8'd30, 8'd255, 8'd90};
  localparam rgb_t AuroraVio  = '{8'd140, 8'd30, 8'd255};

  // Divide a value below 65536 by 255; the multiplier is shifts and adds.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] p;
    p = {16'b0, x} * 32'h00008081;
    return p[30:23];
  endfunction

  // Triangle wave over one phase turn.
  function automatic logic [7:0] tri_wave(input logic [7:0] p);
    if (p[7]) begin
      return {~p[6:0], 1'b0};
    end
    return {p[6:0], 1'b0};
  endfunction

  // Three-segment colour wheel.
  function automatic rgb_t hue_wheel(input logic [7:0] p);
    logic [7:0] d;
    logic [7:0] t;
    rgb_t       c;
    if (p < 8'd85) begin
      d = p;
    end else if (p < 8'd170) begin
      d = p - 8'd85;
    end else begin
      d = p - 8'd170;
    end
    t = d + d + d;
    if (p < 8'd85) begin
      c = '{8'd255 - t, t, 8'd0};
    end else if (p < 8'd170) begin
      c = '{8'd0, 8'd255 - t, t};
    end else begin
      c = '{t, 8'd0, 8'd255 - t};
    end
    return c;
  endfunction

  // Weighted sum x*(255-a) + y*a + 127, ready for a divide by 255.
  function automatic logic [15:0] mix_sum(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] a);
    logic [15:0] px;
    logic [15:0] py;
    px = 16'(x) * 16'(8'd255 - a);
    py = 16'(y) * 16'(a);
    return px + py + 16'd127;
  endfunction

endpackage

`default_nettype wire

// ===== design/lepg_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module lepg_div #(
  parameter int unsigned DvdW = 72,
  parameter int unsigned DsrW = 25
) (
  input  wire logic            clk_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DsrW-1:0] divisor_i,
  output logic      [DvdW-1:0] quotient_o
);

  logic [DsrW-1:0] rem_q [DvdW];
  logic [DvdW-1:0] num_q [DvdW];
  logic [DvdW-1:0] quo_q [DvdW];
  logic [DsrW-1:0] dsr_q [DvdW];

  for (genvar s = 0; s < DvdW; s++) begin : g_stage
    logic [DsrW-1:0] rem_in;
    logic [DvdW-1:0] num_in;
    logic [DvdW-1:0] quo_in;
    logic [DsrW-1:0] dsr_in;
    logic [DsrW:0]   trial;
    logic [DsrW:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend_i;
      assign quo_in = '0;
      assign dsr_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dsr_in = dsr_q[s-1];
    end

    // Bring down the next dividend bit and try a subtraction.
    assign trial = {rem_in, num_in[DvdW-1]};
    assign diff  = trial - {1'b0, dsr_in};

    always_ff @(posedge clk_i) begin
      if (trial >= {1'b0, dsr_in}) begin
        rem_q[s] <= diff[DsrW-1:0];
        quo_q[s] <= {quo_in[DvdW-2:0], 1'b1};
      end else begin
        rem_q[s] <= trial[DsrW-1:0];
        quo_q[s] <= {quo_in[DvdW-2:0], 1'b0};
      end
      num_q[s] <= {num_in[DvdW-2:0], 1'b0};
      dsr_q[s] <= dsr_in;
    end
  end

  assign quotient_o = quo_q[DvdW-1];

endmodule

`default_nettype wire

// ===== design/led_effect_pixel_generator.sv =====
// LED effect pixel generator: top level, configuration registers and pipeline.
// Depends on lepg_pkg and on lepg_div for the time and position divisions.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------------------
//  cfg      | cfg_we_i           | cfg_idx_i, cfg_data_i
//  input    | start, busy        | now_us_i, pixel_index_i
//  result   | done_o (strobe)    | red_o, green_o, blue_o, valid_res_o
//
// One transaction is accepted in every cycle; busy is always low.
// Each result passes through three stages that work out the period, the 72-stage
// time divider (64 quotient bits plus 8 phase bits) and seven colour stages
// after it.
// Reset clears the transaction valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none

module led_effect_pixel_generator
  import lepg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] now_us_i,
  input  wire logic [9:0]  pixel_index_i,
  output logic             done_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             valid_res_o
);

  localparam int unsigned DivW    = 72;
  localparam int unsigned SideW   = 19;
  localparam int unsigned StDiv   = 3 + DivW;
  localparam int unsigned SideEnd = 1 + SideW;
  localparam int unsigned StOut   = StDiv + 7;

  // Configuration registers.
  logic [3:0]  effect_mode_q;
  logic [7:0]  speed_q;
  logic [7:0]  intensity_q;
  logic [7:0]  color_red_q;
  logic [7:0]  color_green_q;
  logic [7:0]  color_blue_q;
  logic [10:0] led_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_mode_q <= EffSolid;
      speed_q       <= 8'd0;
      intensity_q   <= 8'd255;
      color_red_q   <= 8'd255;
      color_green_q <= 8'd255;
      color_blue_q  <= 8'd255;
      led_count_q   <= 11'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEffectMode: effect_mode_q <= cfg_data_i[3:0];
        RegSpeed:      speed_q       <= cfg_data_i[7:0];
        RegIntensity:  intensity_q   <= cfg_data_i[7:0];
        RegColorRed:   color_red_q   <= cfg_data_i[7:0];
        RegColorGreen: color_green_q <= cfg_data_i[7:0];
        RegColorBlue:  color_blue_q  <= cfg_data_i[7:0];
        RegLedCount:   led_count_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  rgb_t base_rgb;
  assign base_rgb = '{color_red_q, color_green_q, color_blue_q};

  // Effect depths that follow from the intensity alone.
  logic [7:0] candle_depth;
  logic [7:0] twinkle_bg;
  assign candle_depth = 8'd24 + div255(16'(intensity_q) * 16'd72);
  assign twinkle_bg   = 8'd12 + div255(16'(8'd255 - intensity_q) * 16'd44);

  // Valid bits and per-item flags travel alongside the data.
  logic [StOut:1]   vld_q;
  logic [StOut-1:1] ok_q;
  logic [9:0]       idx_q [StDiv:1];
  logic             ok_d;

  always_comb begin
    ok_d = (effect_mode_q inside {[EffSolid:EffTwinkle]}) && (led_count_q != 11'd0) &&
           (led_count_q <= MaxLeds) && ({1'b0, pixel_index_i} < led_count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[StOut-1:1], start & ~busy};
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= {ok_q[StOut-2:1], ok_d};
    idx_q[1] <= pixel_index_i;
    for (int k = 2; k <= StDiv; k++) begin
      idx_q[k] <= idx_q[k-1];
    end
  end

  // Stage 1: pick the time span of the effect, scale its range by speed and set up the position division.
  logic [24:0] slow_d;
  logic [24:0] range_d;
  logic [24:0] slow1_q;
  logic [31:0] prod1_q;
  logic [63:0] now1_q;
  logic [18:0] side_dvd_d;
  logic [10:0] side_dsr_d;
  logic [18:0] side_dvd_q;
  logic [10:0] side_dsr_q;

  always_comb begin
    case (effect_mode_q)
      EffBreath: begin
        slow_d  = BreathSlow;
        range_d = BreathSlow - BreathFast;
      end
      EffCandle: begin
        slow_d  = CandleSlow;
        range_d = CandleSlow - CandleFast;
      end
      EffAurora: begin
        slow_d  = AuroraSlow;
        range_d = AuroraSlow - AuroraFast;
      end
      EffTwinkle: begin
        slow_d  = TwinkleSlow;
        range_d = TwinkleSlow - TwinkleFast;
      end
      default: begin
        slow_d  = RainbowSlow;
        range_d = RainbowSlow - RainbowFast;
      end
    endcase
    // Position along the strip, divided by the count (less one for sunset) in its own divider.
    case (effect_mode_q)
      EffAurora: begin
        side_dvd_d = {1'b0, pixel_index_i, 8'b0} + {2'b0, pixel_index_i, 7'b0};
        side_dsr_d = led_count_q;
      end
      EffSunset: begin
        side_dvd_d = {1'b0, pixel_index_i, 8'b0} - {9'b0, pixel_index_i};
        side_dsr_d = led_count_q - 11'd1;
      end
      default: begin
        side_dvd_d = {1'b0, pixel_index_i, 8'b0};
        side_dsr_d = led_count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    slow1_q    <= slow_d;
    prod1_q    <= 32'(range_d) * 32'(speed_q);
    now1_q     <= now_us_i;
    side_dvd_q <= side_dvd_d;
    side_dsr_q <= side_dsr_d;
  end

  // Stage 2: divide the scaled range by 255 through the reciprocal.
  logic [63:0] recip_full;
  logic [23:0] q255_q;
  logic [24:0] slow2_q;
  logic [63:0] now2_q;

  assign recip_full = {32'b0, prod1_q} * {32'b0, Recip255};

  always_ff @(posedge clk_i) begin
    q255_q  <= recip_full[62:39];
    slow2_q <= slow1_q;
    now2_q  <= now1_q;
  end

  // Stage 3: the period or step itself.
  logic [24:0] span3_q;
  logic [63:0] now3_q;

  always_ff @(posedge clk_i) begin
    span3_q <= slow2_q - {1'b0, q255_q};
    now3_q  <= now2_q;
  end

  // Time divider: quotient of now*256 by the span gives tick and phase.
  logic [DivW-1:0] time_quo;

  lepg_div #(
    .DvdW(DivW),
    .DsrW(25)
  ) u_time_div (
    .clk_i      (clk_i),
    .dividend_i ({now3_q, 8'h00}),
    .divisor_i  (span3_q),
    .quotient_o (time_quo)
  );

  // Position divider and the delay that lines it up with the time divider.
  logic [SideW-1:0] side_quo;
  logic [7:0]       sp_q [StDiv:SideEnd+1];

  lepg_div #(
    .DvdW(SideW),
    .DsrW(11)
  ) u_pos_div (
    .clk_i      (clk_i),
    .dividend_i (side_dvd_q),
    .divisor_i  (side_dsr_q),
    .quotient_o (side_quo)
  );

  always_ff @(posedge clk_i) begin
    sp_q[SideEnd+1] <= side_quo[7:0];
    for (int k = SideEnd + 2; k <= StDiv; k++) begin
      sp_q[k] <= sp_q[k-1];
    end
  end

  // Colour stage 1: seed, colour end points, mix weight and wave product.
  logic [7:0]  ph;
  logic [31:0] tk;
  logic [7:0]  sp;
  logic [7:0]  hue;
  logic [7:0]  wave_ph;
  logic [31:0] seed_mul;
  rgb_t        x_d;
  rgb_t        y_d;
  logic [7:0]  a_d;
  logic [15:0] mprod_d;
  logic [31:0] seed_q;
  rgb_t        x_q;
  rgb_t        y_q;
  logic [7:0]  a_q;
  logic [15:0] mprod_q;

  assign ph       = time_quo[7:0];
  assign tk       = time_quo[39:8];
  assign seed_mul = (effect_mode_q == EffCandle) ? SeedCandle : SeedTwinkle;

  always_comb begin
    sp      = sp_q[StDiv];
    if ((effect_mode_q == EffSunset) && (led_count_q <= 11'd1)) begin
      sp = 8'd0;
    end
    hue     = ph + sp;
    wave_ph = {ph[6:0], 1'b0} + sp;
    x_d     = base_rgb;
    y_d     = base_rgb;
    a_d     = 8'd0;
    mprod_d = 16'd0;
    case (effect_mode_q)
      EffRainbow: begin
        x_d = hue_wheel(hue);
        y_d = x_d;
      end
      EffBreath: begin
        mprod_d = 16'(tri_wave(ph)) * 16'(intensity_q);
      end
      EffWarm: begin
        x_d = WarmRgb;
        y_d = WarmRgb;
      end
      EffBias: begin
        x_d = BiasRgb;
        y_d = BiasRgb;
      end
      EffSunset: begin
        x_d = sp[7] ? SunsetB : SunsetA;
        y_d = sp[7] ? SunsetC : SunsetB;
        a_d = {sp[6:0], 1'b0};
      end
      EffCandle: begin
        x_d = CandleRgb;
        y_d = CandleRgb;
      end
      EffAurora: begin
        case (hue[7:6])
          2'd0: begin
            x_d = AuroraBlue;
            y_d = AuroraCyan;
          end
          2'd1: begin
            x_d = AuroraCyan;
            y_d = AuroraGrn;
          end
          2'd2: begin
            x_d = AuroraGrn;
            y_d = AuroraVio;
          end
          default: begin
            x_d = AuroraVio;
            y_d = AuroraBlue;
          end
        endcase
        a_d     = {hue[5:0], 2'b00};
        mprod_d = 16'({1'b0, intensity_q[7:1]}) * 16'(tri_wave(wave_ph));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    seed_q  <= tk * seed_mul + 32'(idx_q[StDiv]);
    x_q     <= x_d;
    y_q     <= y_d;
    a_q     <= a_d;
    mprod_q <= mprod_d;
  end

  // Colour stage 2: first hash round, mix sums and the breathing or aurora level.
  logic [31:0] hmix1;
  logic [7:0]  lvlab_d;
  logic [31:0] v1_q;
  sum3_t       mix_q;
  logic [7:0]  lvlab2_q;

  assign hmix1 = seed_q ^ (seed_q >> 16);

  always_comb begin
    if (effect_mode_q == EffAurora) begin
      lvlab_d = (8'd255 - {1'b0, intensity_q[7:1]}) + div255(mprod_q);
    end else begin
      lvlab_d = (8'd255 - intensity_q) + div255(mprod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q     <= hmix1 * HashMulA;
    mix_q    <= '{mix_sum(x_q.r, y_q.r, a_q), mix_sum(x_q.g, y_q.g, a_q),
                  mix_sum(x_q.b, y_q.b, a_q)};
    lvlab2_q <= lvlab_d;
  end

  // Colour stage 3: second hash round and the mixed colour.
  logic [31:0] hmix2;
  logic [31:0] v2_q;
  rgb_t        col3_q;
  logic [7:0]  lvlab3_q;

  assign hmix2 = v1_q ^ (v1_q >> 15);

  always_ff @(posedge clk_i) begin
    v2_q     <= hmix2 * HashMulB;
    col3_q   <= '{div255(mix_q.r), div255(mix_q.g), div255(mix_q.b)};
    lvlab3_q <= lvlab2_q;
  end

  // Colour stage 4: noise byte, flicker product and sparkle test.
  logic [31:0] hmix3;
  logic [15:0] cprod_q;
  logic        sparkle_q;
  rgb_t        col4_q;
  logic [7:0]  lvlab4_q;

  assign hmix3 = v2_q ^ (v2_q >> 16);

  always_ff @(posedge clk_i) begin
    cprod_q   <= 16'(hmix3[7:0]) * 16'(candle_depth);
    sparkle_q <= {1'b0, hmix3[7:0]} < (9'd8 + 9'(intensity_q[7:3]));
    col4_q    <= col3_q;
    lvlab4_q  <= lvlab3_q;
  end

  // Colour stage 5: the brightness level for the effect.
  logic [7:0] lvl_d;
  logic [7:0] lvl_q;
  rgb_t       col5_q;

  always_comb begin
    case (effect_mode_q)
      EffBreath, EffAurora: lvl_d = lvlab4_q;
      EffCandle:            lvl_d = 8'd255 - div255(cprod_q);
      EffTwinkle:           lvl_d = sparkle_q ? 8'd255 : twinkle_bg;
      default:              lvl_d = 8'd255;
    endcase
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    col5_q <= col4_q;
  end

  // Colour stage 6: scale sums.
  sum3_t scl_q;

  always_ff @(posedge clk_i) begin
    scl_q <= '{16'(col5_q.r) * 16'(lvl_q) + 16'd127, 16'(col5_q.g) * 16'(lvl_q) + 16'd127,
               16'(col5_q.b) * 16'(lvl_q) + 16'd127};
  end

  // Output registers; an item that is not rendered shows black.
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;
  logic       valid_res_q;

  always_ff @(posedge clk_i) begin
    valid_res_q <= ok_q[StOut-1];
    if (ok_q[StOut-1]) begin
      red_q   <= div255(scl_q.r);
      green_q <= div255(scl_q.g);
      blue_q  <= div255(scl_q.b);
    end else begin
      red_q   <= 8'd0;
      green_q <= 8'd0;
      blue_q  <= 8'd0;
    end
  end

  assign done_o      = vld_q[StOut];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign valid_res_o = valid_res_q;

  // A pixel that is not rendered is always black.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0))
    else $error("unrendered pixel is not black");

  // Every accepted transaction leaves after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##StOut done_o)
    else $error("result missing after accepted transaction");

  // No result appears without a transaction the fixed latency earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##StOut !done_o)
    else $error("result without a transaction");

endmodule

`default_nettype wire

// ===== tb/tb_led_effect_pixel_generator.sv =====
// Testbench for the LED effect pixel generator: directed and random pixels
// checked against a local colour predictor. Depends on lepg_pkg and the top level.
`timescale 1ns / 1ps

module tb_led_effect_pixel_generator;
  import lepg_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned IdlePct  = 33;

  typedef struct {
    logic [63:0] now;
    logic [9:0]  idx;
  } pixel_req_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       ok;
  } pixel_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] now_us_i = '0;
  logic [9:0]  pixel_index_i = '0;
  logic        done_o;
  logic [7:0]  red_o, green_o, blue_o;
  logic        valid_res_o;

  // Mirror of the configuration registers.
  logic [3:0]  cur_mode = EffSolid;
  logic [7:0]  cur_speed = 8'd0;
  logic [7:0]  cur_depth = 8'd255;
  logic [7:0]  cur_r = 8'd255, cur_g = 8'd255, cur_b = 8'd255;
  logic [10:0] cur_count = 11'd0;

  pixel_req_t pending_pixels[$];
  pixel_res_t expected_pixels[$];
  int unsigned mismatches = 0;
  bit idle_on = 1'b1;

  led_effect_pixel_generator DUT (.*);

  always #10 clk_i = ~clk_i;

  // Colour arithmetic for the predictor.
  function automatic int unsigned scale_ch(int unsigned v, int unsigned lvl);
    return ((v * (lvl & 255) + 127) / 255) & 255;
  endfunction

  function automatic pixel_res_t scale_col(pixel_res_t c, int unsigned lvl);
    pixel_res_t o;
    o.r = scale_ch(c.r, lvl); o.g = scale_ch(c.g, lvl); o.b = scale_ch(c.b, lvl);
    o.ok = c.ok;
    return o;
  endfunction

  function automatic pixel_res_t make_col(int unsigned r, int unsigned g, int unsigned b);
    pixel_res_t o;
    o.r = r[7:0]; o.g = g[7:0]; o.b = b[7:0]; o.ok = 1'b1;
    return o;
  endfunction

  function automatic pixel_res_t blend_col(pixel_res_t x, pixel_res_t y, int unsigned a);
    int unsigned w;
    w = a & 255;
    return make_col((x.r * (255 - w) + y.r * w + 127) / 255,
                    (x.g * (255 - w) + y.g * w + 127) / 255,
                    (x.b * (255 - w) + y.b * w + 127) / 255);
  endfunction

  function automatic pixel_res_t wheel_col(int unsigned p);
    p = p & 255;
    if (p < 85) return make_col(255 - p * 3, p * 3, 0);
    if (p < 170) return make_col(0, 255 - (p - 85) * 3, (p - 85) * 3);
    return make_col((p - 170) * 3, 0, 255 - (p - 170) * 3);
  endfunction

  function automatic int unsigned triangle(int unsigned p);
    p = p & 255;
    return (p < 128) ? (p * 2) & 255 : ((255 - p) * 2) & 255;
  endfunction

  function automatic logic [31:0] mix_hash(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * HashMulA;
    v = v ^ (v >> 15);
    v = v * HashMulB;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic longint unsigned period_us(longint unsigned slow, longint unsigned fast);
    return slow - ((slow - fast) * longint'(cur_speed)) / 255;
  endfunction

  function automatic int unsigned phase_at(logic [63:0] now, longint unsigned per);
    if (per == 0) return 0;
    return (((now % per) * 256) / per) & 255;
  endfunction

  function automatic logic [31:0] tick_at(logic [63:0] now, longint unsigned step);
    logic [63:0] q;
    if (step == 0) return '0;
    q = now / step;
    return q[31:0];
  endfunction

  function automatic pixel_res_t aurora_col(int unsigned p);
    pixel_res_t bl, cy, gr, vi;
    bl = make_col(16, 70, 255);  cy = make_col(0, 220, 200);
    gr = make_col(30, 255, 90);  vi = make_col(140, 30, 255);
    p = p & 255;
    if (p < 64) return blend_col(bl, cy, p * 4);
    if (p < 128) return blend_col(cy, gr, (p - 64) * 4);
    if (p < 192) return blend_col(gr, vi, (p - 128) * 4);
    return blend_col(vi, bl, (p - 192) * 4);
  endfunction

  // Expected colour of one pixel under the current settings.
  function automatic pixel_res_t predict_pixel(pixel_req_t q);
    pixel_res_t  c, base;
    int unsigned idx, cnt, ph, sp, lvl, depth;
    logic [31:0] tk, nz;
    idx = q.idx; cnt = cur_count;
    base = make_col(cur_r, cur_g, cur_b);
    c = '{8'd0, 8'd0, 8'd0, 1'b0};
    if (cur_mode < EffSolid || cur_mode > EffTwinkle || cnt == 0 || cnt > MaxLeds ||
        idx >= cnt) begin
      return c;
    end
    case (cur_mode)
      EffSolid: c = base;
      EffRainbow: begin
        ph = phase_at(q.now, period_us(RainbowSlow, RainbowFast));
        c = wheel_col(ph + (idx * 256) / cnt);
      end
      EffBreath: begin
        ph = triangle(phase_at(q.now, period_us(BreathSlow, BreathFast)));
        lvl = (255 - cur_depth) + (ph * cur_depth) / 255;
        c = scale_col(base, lvl);
      end
      EffWarm: c = make_col(255, 172, 92);
      EffBias: c = make_col(255, 249, 253);
      EffSunset: begin
        sp = (cnt <= 1) ? 0 : ((idx * 255) / (cnt - 1)) & 255;
        if (sp < 128) c = blend_col(make_col(255, 78, 18), make_col(225, 22, 96), sp * 2);
        else c = blend_col(make_col(225, 22, 96), make_col(92, 18, 130), (sp - 128) * 2);
      end
      EffCandle: begin
        tk = tick_at(q.now, period_us(CandleSlow, CandleFast));
        nz = mix_hash(tk * SeedCandle + 32'(idx));
        depth = 24 + (cur_depth * 72) / 255;
        c = scale_col(make_col(255, 116, 22), 255 - (nz[7:0] * depth) / 255);
      end
      EffAurora: begin
        ph = phase_at(q.now, period_us(AuroraSlow, AuroraFast));
        sp = ((idx * 384) / cnt) & 255;
        depth = 255 - cur_depth / 2;
        lvl = depth + ((255 - depth) * triangle(ph * 2 + sp)) / 255;
        c = scale_col(aurora_col(ph + sp), lvl);
      end
      default: begin
        tk = tick_at(q.now, period_us(TwinkleSlow, TwinkleFast));
        lvl = 12 + ((255 - cur_depth) * 44) / 255;
        nz = mix_hash(tk * SeedTwinkle + 32'(idx));
        c = scale_col(base, (nz[7:0] < 8 + cur_depth / 8) ? 255 : lvl);
      end
    endcase
    c.ok = 1'b1;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Driver: records each accepted transaction and offers the next pixel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_pixels.push_back(predict_pixel('{now_us_i, pixel_index_i}));
      end
      if (pending_pixels.size() > 0 && (!idle_on || $urandom_range(0, 99) >= IdlePct)) begin
        pixel_req_t q;
        q = pending_pixels.pop_front();
        start <= 1'b1;
        now_us_i <= q.now;
        pixel_index_i <= q.idx;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares each strobed result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        pixel_res_t e;
        e = expected_pixels.pop_front();
        if (red_o !== e.r) report_mismatch($sformatf("red %0d, want %0d", red_o, e.r));
        if (green_o !== e.g) report_mismatch($sformatf("green %0d, want %0d", green_o, e.g));
        if (blue_o !== e.b) report_mismatch($sformatf("blue %0d, want %0d", blue_o, e.b));
        if (valid_res_o !== e.ok)
          report_mismatch($sformatf("valid %0b, want %0b", valid_res_o, e.ok));
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegEffectMode: cur_mode = val[3:0];
      RegSpeed:      cur_speed = val[7:0];
      RegIntensity:  cur_depth = val[7:0];
      RegColorRed:   cur_r = val[7:0];
      RegColorGreen: cur_g = val[7:0];
      RegColorBlue:  cur_b = val[7:0];
      RegLedCount:   cur_count = val[10:0];
      default: ;
    endcase
  endtask

  task automatic queue_pixel(input logic [63:0] now, input logic [9:0] idx);
    pending_pixels.push_back('{now, idx});
  endtask

  // Waits for every outstanding pixel, so that registers may be changed.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || start || expected_pixels.size() != 0);
    repeat (5) @(negedge clk_i);
  endtask

  function automatic int unsigned pick_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [63:0] pick_time();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 40000000));
      2: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20000000));
      default: return {32'($urandom_range(0, 3)), $urandom};
    endcase
  endfunction

  // Stimulus: directed corners, then random settings with random pixels.
  initial begin
    int unsigned cnt, lim;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Every effect code at full strip length, extreme speed and depth.
    write_reg(RegLedCount, MaxLeds);
    write_reg(RegSpeed, 255);
    write_reg(RegIntensity, 0);
    for (int m = 0; m < 16; m++) begin
      write_reg(RegEffectMode, m);
      queue_pixel((m % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0, (m % 2) ? 10'd1023 : 10'd0);
      drain();
    end
    // Bad counts, a single-LED strip and an index past the end.
    write_reg(RegEffectMode, EffSunset);
    write_reg(RegLedCount, 0);
    queue_pixel(64'd5, 10'd0);
    drain();
    write_reg(RegLedCount, 2047);
    queue_pixel(64'd5, 10'd3);
    drain();
    write_reg(RegLedCount, 1);
    queue_pixel(64'd7, 10'd0);
    queue_pixel(64'd7, 10'd1);
    drain();
    write_reg(RegUnused, 2047);
    write_reg(RegLedCount, 5);
    queue_pixel(64'd9, 10'd7);
    drain();

    // Random settings, each followed by a burst of pixels.
    for (int ph = 0; ph < 20; ph++) begin
      idle_on = !(ph >= 6 && ph <= 9);
      write_reg(RegEffectMode, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(1, 9));
      write_reg(RegSpeed, pick_level());
      write_reg(RegIntensity, pick_level());
      write_reg(RegColorRed, pick_level());
      write_reg(RegColorGreen, pick_level());
      write_reg(RegColorBlue, pick_level());
      case ($urandom_range(0, 19))
        0: cnt = 0;
        1: cnt = $urandom_range(1025, 2047);
        2: cnt = 1024;
        3: cnt = 1;
        4, 5, 6, 7, 8, 9: cnt = $urandom_range(2, 16);
        default: cnt = $urandom_range(2, 1024);
      endcase
      write_reg(RegLedCount, cnt);
      if ($urandom_range(0, 4) == 0) write_reg(RegUnused, $urandom);
      lim = (cnt == 0) ? 1024 : ((cnt > 1024) ? 1024 : cnt);
      for (int k = 0; k < 48; k++) begin
        queue_pixel(pick_time(), ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                             : $urandom_range(0, lim - 1));
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lepg_pkg.sv
design/lepg_div.sv
design/led_effect_pixel_generator.sv
tb/tb_led_effect_pixel_generator.sv
